// ----- rtl/esp3_pkg.sv -----
// Types and constants shared by the ESP3 frame field parser.
package esp3_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned INDEX_W    = 17;
    localparam int unsigned DLEN_W     = 16;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned RESULT_W   = 144;
    localparam int unsigned VALID_W    = 5;

    localparam logic [INDEX_W-1:0] INDEX_MAX      = '1;
    localparam logic [INDEX_W-1:0] POS_DLEN_HI    = 17'd1;
    localparam logic [INDEX_W-1:0] POS_DLEN_LO    = 17'd2;
    localparam logic [INDEX_W-1:0] POS_OLEN       = 17'd3;
    localparam logic [INDEX_W-1:0] POS_TYPE       = 17'd4;
    localparam logic [INDEX_W-1:0] DATA_START     = 17'd6;
    localparam logic [INDEX_W-1:0] FRAME_OVERHEAD = 17'd7;

    localparam logic [BYTE_W-1:0] ERP1_CODE_RST  = 8'd1;
    localparam logic [BYTE_W-1:0] ERP2_CODE_RST  = 8'd10;
    localparam logic [BYTE_W-1:0] RMGMT_CODE_RST = 8'd7;

    localparam logic [3:0] REPEAT_MASK = 4'hF;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ERP1_CODE  = 2'd0,
        REG_ERP2_CODE  = 2'd1,
        REG_RMGMT_CODE = 2'd2
    } cfg_reg_t;

    typedef enum logic [VALID_W-1:0] {
        FV_RORG   = 5'b00001,
        FV_SENDER = 5'b00010,
        FV_DEST   = 5'b00100,
        FV_RSSI   = 5'b01000,
        FV_RMGMT  = 5'b10000
    } field_valid_t;

    typedef struct packed {
        logic [INDEX_W-1:0] byte_index;
        logic [DLEN_W-1:0]  data_length;
        logic [7:0]         optional_length;
        logic [7:0]         frame_type;
        logic [3:0][7:0]    data_head;
        logic [4:0][7:0]    data_tail;
        logic [8:0][7:0]    optional_head;
        logic [1:0][7:0]    optional_tail;
    } frame_t;

    // last field in the lowest bits
    typedef struct packed {
        logic [4:0]         pad;
        logic [VALID_W-1:0] fields_valid;
        logic [15:0]        rm_manufacturer;
        logic [15:0]        rm_function;
        logic signed [8:0]  rssi_dbm;
        logic [3:0]         repeat_count;
        logic [7:0]         status_byte;
        logic [31:0]        destination_address;
        logic [31:0]        sender_address;
        logic [7:0]         rorg;
        logic [7:0]         packet_type;
        logic               frame_ok;
    } result_t;

endpackage

// ----- rtl/esp3_frame_field_parser.sv -----
// ESP3 frame field parser: byte capture, frame check and field extraction.
// Takes one frame byte per cycle with no gaps needed between bytes or frames;
// the capture registers are updated in the accepting cycle, and the byte
// marked last snapshots the frame. The field extraction runs from that
// snapshot, and the result is registered from it once the output is free.
// One input transaction per cycle is sustained while the result side keeps
// up; when m_tready holds off, one frame snapshot and one result are held and
// s_tready drops only once both are occupied.
module esp3_frame_field_parser (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // [7:0] rx_byte
    input  logic                            s_tlast,   // last_byte
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [0] frame_ok, [8:1] packet_type, [16:9] rorg, [48:17] sender_address,
    // [80:49] destination_address, [88:81] status_byte, [92:89] repeat_count,
    // [101:93] rssi_dbm, [117:102] rm_function, [133:118] rm_manufacturer,
    // [138:134] fields_valid, [143:139] zero
    output logic [esp3_pkg::RESULT_W-1:0]   m_tdata,
    input  logic                            cfg_we,
    input  logic [esp3_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [7:0]                      cfg_wdata
);
    import esp3_pkg::*;

    logic [7:0] erp1_code_reg, erp2_code_reg, rmgmt_code_reg;

    frame_t  frame_reg, frame_next, cap;
    frame_t  snap_reg;
    logic    snap_valid_reg, snap_valid_next;
    result_t res, res_reg;
    logic    m_valid_reg, m_valid_next;

    logic accept, out_free, snap_adv;

    logic [INDEX_W-1:0] pos, data_end, opt_end, d_off, o_off;

    logic [INDEX_W-1:0] sum;
    logic               radio, erp1, rm_ok;
    logic [7:0]         rssi_raw;

    assign out_free = !m_valid_reg || m_tready;
    assign snap_adv = snap_valid_reg && out_free;
    assign s_tready = !snap_valid_reg || out_free;
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            erp1_code_reg  <= ERP1_CODE_RST;
            erp2_code_reg  <= ERP2_CODE_RST;
            rmgmt_code_reg <= RMGMT_CODE_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_ERP1_CODE:  erp1_code_reg  <= cfg_wdata;
                REG_ERP2_CODE:  erp2_code_reg  <= cfg_wdata;
                REG_RMGMT_CODE: rmgmt_code_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // byte capture
    always_comb begin
        pos      = frame_reg.byte_index;
        data_end = DATA_START + {1'b0, frame_reg.data_length};
        opt_end  = data_end + {9'b0, frame_reg.optional_length};
        d_off    = pos - DATA_START;
        o_off    = pos - data_end;
        cap      = frame_reg;
        if (pos == POS_DLEN_HI) begin
            cap.data_length[15:8] = s_tdata;
        end else if (pos == POS_DLEN_LO) begin
            cap.data_length[7:0] = s_tdata;
        end else if (pos == POS_OLEN) begin
            cap.optional_length = s_tdata;
        end else if (pos == POS_TYPE) begin
            cap.frame_type = s_tdata;
        end else if (pos >= DATA_START && pos < data_end) begin
            if (d_off < 17'd4) begin
                cap.data_head[d_off[1:0]] = s_tdata;
            end
            cap.data_tail = {s_tdata, frame_reg.data_tail[4:1]};
        end else if (pos >= data_end && pos < opt_end) begin
            if (o_off < 17'd9) begin
                cap.optional_head[o_off[3:0]] = s_tdata;
            end
            cap.optional_tail = {s_tdata, frame_reg.optional_tail[1]};
        end
        if (pos != INDEX_MAX) begin
            cap.byte_index = pos + 17'd1;
        end
    end

    always_comb begin
        frame_next = frame_reg;
        if (accept) begin
            frame_next = s_tlast ? '0 : cap;
        end
        snap_valid_next = snap_valid_reg;
        if (accept && s_tlast) begin
            snap_valid_next = 1'b1;
        end else if (snap_adv) begin
            snap_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (snap_adv) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    // field extraction from the frame snapshot
    always_comb begin
        sum   = {1'b0, snap_reg.data_length} + {9'b0, snap_reg.optional_length};
        erp1  = snap_reg.frame_type == erp1_code_reg;
        radio = erp1 || snap_reg.frame_type == erp2_code_reg;
        rm_ok = snap_reg.frame_type == rmgmt_code_reg && snap_reg.data_length >= 16'd4 &&
                snap_reg.optional_length >= 8'd10;
        rssi_raw = 8'd0;
        res = '0;
        if (sum != '0 && snap_reg.byte_index == sum + FRAME_OVERHEAD) begin
            res.frame_ok    = 1'b1;
            res.packet_type = snap_reg.frame_type;
            if (radio) begin
                if (snap_reg.data_length >= 16'd1) begin
                    res.rorg         = snap_reg.data_head[0];
                    res.fields_valid = res.fields_valid | FV_RORG;
                end
                if (snap_reg.data_length >= 16'd6) begin
                    res.sender_address = {snap_reg.data_tail[0], snap_reg.data_tail[1],
                                          snap_reg.data_tail[2], snap_reg.data_tail[3]};
                    res.status_byte    = snap_reg.data_tail[4];
                    res.repeat_count   = snap_reg.data_tail[4][3:0] & REPEAT_MASK;
                    res.fields_valid   = res.fields_valid | FV_SENDER;
                end
                if (snap_reg.optional_length >= 8'd5) begin
                    res.destination_address = {snap_reg.optional_head[1],
                                               snap_reg.optional_head[2],
                                               snap_reg.optional_head[3],
                                               snap_reg.optional_head[4]};
                    res.fields_valid = res.fields_valid | FV_DEST;
                end
                if (snap_reg.optional_length >= 8'd2) begin
                    rssi_raw = erp1 ? snap_reg.optional_tail[0] : snap_reg.optional_tail[1];
                    res.rssi_dbm     = 9'sd0 - $signed({1'b0, rssi_raw});
                    res.fields_valid = res.fields_valid | FV_RSSI;
                end
            end else if (rm_ok) begin
                rssi_raw = snap_reg.optional_head[8];
                res.rm_function     = {snap_reg.data_head[0], snap_reg.data_head[1]};
                res.rm_manufacturer = {snap_reg.data_head[2], snap_reg.data_head[3]};
                res.destination_address = {snap_reg.optional_head[0], snap_reg.optional_head[1],
                                           snap_reg.optional_head[2], snap_reg.optional_head[3]};
                res.sender_address = {snap_reg.optional_head[4], snap_reg.optional_head[5],
                                      snap_reg.optional_head[6], snap_reg.optional_head[7]};
                res.rssi_dbm     = 9'sd0 - $signed({1'b0, rssi_raw});
                res.fields_valid = FV_SENDER | FV_DEST | FV_RSSI | FV_RMGMT;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_reg      <= '0;
            snap_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            frame_reg      <= frame_next;
            snap_valid_reg <= snap_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && s_tlast) begin
            snap_reg <= cap;
        end
        if (snap_adv) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = res_reg;

    a_last_snapshots: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_tlast |=> snap_valid_reg && frame_reg.byte_index == '0)
        else $error("last byte did not close the frame");

    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        snap_valid_reg && !out_free |-> !s_tready)
        else $error("input taken while snapshot is blocked");

    a_bad_frame_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !res_reg.frame_ok |-> res_reg == '0)
        else $error("bad frame carries field data");

    a_kind_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && res_reg.fields_valid[4] |-> !res_reg.fields_valid[0] &&
        res_reg.rorg == '0)
        else $error("remote management result carries radio fields");

endmodule
